FILE: src/waveform_integral_minimum_two_channel_core_assert.svh
// Assertion macros used by the core's RTL file.
`ifndef WAVEFORM_INTEGRAL_MINIMUM_TWO_CHANNEL_CORE_ASSERT_SVH
`define WAVEFORM_INTEGRAL_MINIMUM_TWO_CHANNEL_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define WIMC_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wimc assertion failed");
// Next-cycle implication, checked out of reset
`define WIMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wimc assertion failed");
`else
`define WIMC_ASSERT_IMPLIES(label, ante, cons)
`define WIMC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: src/wimc_pkg.sv
// Package: widths and constants of the waveform integral and minimum core.
package wimc_pkg;

  localparam int unsigned MAX_DATA_WORDS = 8192;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LEN_W    = 14;
  localparam int unsigned POS_W    = 13;
  localparam int unsigned SUM_W    = 29;
  localparam int unsigned ACC_W    = SUM_W + 1;
  localparam int unsigned MIN_W    = SAMPLE_W + 1;
  localparam int unsigned IDX_W    = 13;

  localparam logic [SUM_W-1:0] SUM_LIMIT = '1;
  localparam logic [MIN_W-1:0] MIN_RESET = MIN_W'(1) << SAMPLE_W;
  localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_DATA_WORDS);

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [ACC_W-1:0]    acc_t;
  typedef logic [MIN_W-1:0]    min_t;
  typedef logic [IDX_W-1:0]    idx_t;

endpackage

FILE: src/wimc_if.sv
// Interfaces: waveform word channel and channel summary channel.
interface wimc_in_if
  import wimc_pkg::*;
  ();
  logic  valid;
  logic  ready;
  word_t sample_word;
  len_t  data_words;

  modport source (output valid, output sample_word, output data_words, input ready);
  modport sink   (input valid, input sample_word, input data_words, output ready);
endinterface

interface wimc_out_if
  import wimc_pkg::*;
  ();
  logic    valid;
  logic    ready;
  logic    channel;
  sum_t    integral;
  sample_t minimum_value;
  idx_t    minimum_index;

  modport source (output valid, output channel, output integral, output minimum_value,
                  output minimum_index, input ready);
  modport sink   (input valid, input channel, input integral, input minimum_value,
                  input minimum_index, output ready);
endinterface

FILE: src/waveform_integral_minimum_two_channel_core.sv
// Top level: two-channel waveform integral and minimum finder.
// A channel's last word passes the input register, then the output register, to out_ch.
// Throughput: one waveform word per cycle, except during the stall below.
// An input register and an output register part the two sides, so input stalls only
// when a summary is pending and the output is held.
// Reset: synchronous, active low; clears the event position and the channel accumulators.
`include "waveform_integral_minimum_two_channel_core_assert.svh"

module waveform_integral_minimum_two_channel_core
  import wimc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  wimc_in_if.sink    in_ch,
  wimc_out_if.source out_ch
);

  // Input register
  logic  s1_valid_r;
  word_t s1_word_r;
  len_t  s1_len_r;

  // Event and channel state
  pos_t  pos_r;
  len_t  len_r;
  sum_t  sum_r;
  min_t  min_r;
  idx_t  idx_r;

  // Output register
  logic    out_valid_r;
  logic    out_chan_r;
  sum_t    out_sum_r;
  sample_t out_min_r;
  idx_t    out_idx_r;

  // Update logic
  len_t    len_in;
  len_t    len_eff;
  pos_t    half;
  len_t    pos_inc;
  logic    in_ch0;
  pos_t    offset;
  sample_t lo;
  sample_t hi;
  idx_t    idx_lo;
  idx_t    idx_hi;
  acc_t    sum_full;
  sum_t    sum_nxt;
  min_t    min_mid;
  idx_t    idx_mid;
  min_t    min_nxt;
  idx_t    idx_nxt;
  logic    end0;
  logic    end1;
  logic    emit;
  logic    s1_go;

  // Clamp the event length and latch it on the first word of an event
  always_comb begin
    if (s1_len_r < LEN_MIN) begin
      len_in = LEN_MIN;
    end else if (s1_len_r > LEN_MAX) begin
      len_in = LEN_MAX;
    end else begin
      len_in = s1_len_r;
    end
    len_eff = (pos_r == '0) ? len_in : len_r;
  end

  // Locate the word within its channel
  always_comb begin
    half    = len_eff[LEN_W-1:1];
    pos_inc = {1'b0, pos_r} + LEN_W'(1);
    in_ch0  = (pos_r < half);
    offset  = in_ch0 ? pos_r : pos_r - half;
    idx_lo  = {offset[IDX_W-2:0], 1'b0};
    idx_hi  = {offset[IDX_W-2:0], 1'b1};
    end0    = (pos_inc == {1'b0, half});
    end1    = (pos_inc >= len_eff);
    emit    = end0 || end1;
  end

  // Accumulate both samples: saturating sum, first minimum wins ties
  always_comb begin
    lo       = s1_word_r[SAMPLE_W-1:0];
    hi       = s1_word_r[WORD_W-1:SAMPLE_W];
    sum_full = ACC_W'(sum_r) + ACC_W'(lo) + ACC_W'(hi);
    sum_nxt  = (sum_full > ACC_W'(SUM_LIMIT)) ? SUM_LIMIT : sum_full[SUM_W-1:0];
    if ({1'b0, lo} < min_r) begin
      min_mid = {1'b0, lo};
      idx_mid = idx_lo;
    end else begin
      min_mid = min_r;
      idx_mid = idx_r;
    end
    if ({1'b0, hi} < min_mid) begin
      min_nxt = {1'b0, hi};
      idx_nxt = idx_hi;
    end else begin
      min_nxt = min_mid;
      idx_nxt = idx_mid;
    end
  end

  // Advance unless a summary is due and the output register is blocked
  assign s1_go       = s1_valid_r && (!emit || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_go;

  // Hold the input transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      s1_word_r <= in_ch.sample_word;
      s1_len_r  <= in_ch.data_words;
    end
  end

  // Update event position and channel accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      len_r <= '0;
      sum_r <= '0;
      min_r <= MIN_RESET;
      idx_r <= '0;
    end else if (s1_go) begin
      pos_r <= end1 ? '0 : pos_inc[POS_W-1:0];
      len_r <= len_eff;
      if (emit) begin
        sum_r <= '0;
        min_r <= MIN_RESET;
        idx_r <= '0;
      end else begin
        sum_r <= sum_nxt;
        min_r <= min_nxt;
        idx_r <= idx_nxt;
      end
    end
  end

  // Load the summary transaction, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_go && emit) begin
      out_chan_r <= !in_ch0;
      out_sum_r  <= sum_nxt;
      out_min_r  <= min_nxt[SAMPLE_W-1:0];
      out_idx_r  <= idx_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.channel       = out_chan_r;
  assign out_ch.integral      = out_sum_r;
  assign out_ch.minimum_value = out_min_r;
  assign out_ch.minimum_index = out_idx_r;

  // Checks on event tracking and accumulators
  `WIMC_ASSERT_IMPLIES(a_pos_in_event, pos_r != '0, {1'b0, pos_r} < len_r)
  `WIMC_ASSERT_IMPLIES(a_len_in_range, pos_r != '0, (len_r >= LEN_MIN) && (len_r <= LEN_MAX))
  `WIMC_ASSERT_NEXT(a_clear_after_emit, s1_go && emit,
                    (sum_r == '0) && (min_r == MIN_RESET) && out_valid_r)
  `WIMC_ASSERT_NEXT(a_hold_when_blocked, s1_valid_r && emit && out_valid_r && !out_ch.ready,
                    s1_valid_r && $stable(pos_r) && $stable(sum_r))

endmodule

FILE: sim/tb.sv
// Testbench for the two-channel waveform integral and minimum core.
`timescale 1ns / 100ps

module tb;
  import wimc_pkg::*;

  localparam int          ITEM_TARGET  = 1350;
  localparam int          LONG_WORDS   = 300;
  localparam int          HOLD_CYCLES  = 250;
  localparam int          QUIET_LIMIT  = 4000;
  localparam int          DRAIN_CYCLES = 8;
  localparam logic [7:0]  STALL_MASK   = 8'b1011_0010;

  // Receiver stall modes
  localparam logic [1:0] RX_OPEN   = 2'd0;
  localparam logic [1:0] RX_COIN   = 2'd1;
  localparam logic [1:0] RX_SPARSE = 2'd2;
  localparam logic [1:0] RX_MASK   = 2'd3;

  // Sample content styles
  localparam int STYLE_ANY  = 0;
  localparam int STYLE_TIES = 1;
  localparam int STYLE_HIGH = 2;
  localparam int STYLE_ONES = 3;

  typedef struct {
    word_t word;
    len_t  words;
  } waveform_word_t;

  typedef struct {
    logic    channel;
    sum_t    integral;
    sample_t minimum_value;
    idx_t    minimum_index;
  } summary_t;

  logic clk;
  logic rst_n;

  wimc_in_if  in_bus ();
  wimc_out_if out_bus ();

  waveform_integral_minimum_two_channel_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  waveform_word_t pending_words[$];
  summary_t       expected_summaries[$];

  // Channel accumulator mirror
  pos_t ev_pos       = '0;
  len_t ev_len       = '0;
  acc_t chan_sum     = '0;
  min_t chan_min     = MIN_RESET;
  idx_t chan_min_idx = '0;

  int words_total       = 0;
  int words_sent        = 0;
  int events_total      = 0;
  int summaries_checked = 0;
  int error_count       = 0;
  int burst_left        = 0;
  int gap_left          = 0;
  int hold_left         = 0;
  bit hold_done         = 1'b0;
  int quiet_cycles      = 0;
  logic [8:0] pace_cnt  = '0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch: %s got %0d expected %0d (summary %0d)", what, got, want,
             summaries_checked);
    error_count++;
  endtask

  // Fold one sample into the running channel sum and minimum
  task automatic fold_sample(sample_t value, int unsigned idx);
    int unsigned total;
    total = int'(chan_sum) + int'(value);
    chan_sum = (total > SUM_LIMIT) ? acc_t'(SUM_LIMIT) : acc_t'(total);
    if ({1'b0, value} < chan_min) begin
      chan_min     = {1'b0, value};
      chan_min_idx = idx_t'(idx);
    end
  endtask

  // Advance the event position by one word and queue any channel summary
  task automatic track_word(word_t word, len_t words);
    int unsigned pos, len, half, offs;
    logic        chan;
    summary_t    summary;
    pos = ev_pos;
    if (pos == 0) begin
      len = words;
      if (len < LEN_MIN) len = LEN_MIN;
      if (len > LEN_MAX) len = LEN_MAX;
      ev_len = len_t'(len);
    end
    half = ev_len / 2;
    if (pos < half) begin
      chan = 1'b0;
      offs = pos;
    end else begin
      chan = 1'b1;
      offs = pos - half;
    end
    fold_sample(word[15:0], offs * 2);
    fold_sample(word[31:16], offs * 2 + 1);
    ev_pos = (pos + 1 >= ev_len) ? '0 : pos_t'(pos + 1);
    if (pos + 1 == half || pos + 1 >= ev_len) begin
      summary.channel       = chan;
      summary.integral      = sum_t'(chan_sum);
      summary.minimum_value = sample_t'(chan_min);
      summary.minimum_index = chan_min_idx;
      expected_summaries.push_back(summary);
      chan_sum     = '0;
      chan_min     = MIN_RESET;
      chan_min_idx = '0;
    end
  endtask

  function automatic void push_word(word_t word, len_t words);
    waveform_word_t item;
    item.word  = word;
    item.words = words;
    pending_words.push_back(item);
    words_total++;
  endfunction

  function automatic sample_t pick_sample(int style);
    case (style)
      STYLE_TIES: return sample_t'($urandom_range(0, 3));
      STYLE_HIGH: return 16'hFFFF - sample_t'($urandom_range(0, 15));
      STYLE_ONES: return 16'hFFFF;
      default:    return sample_t'($urandom);
    endcase
  endfunction

  // Queue one event; later words carry a random length field that must be ignored
  function automatic int add_event(len_t field, int style);
    int len;
    len = field;
    if (len < LEN_MIN) len = LEN_MIN;
    if (len > LEN_MAX) len = LEN_MAX;
    for (int i = 0; i < len; i++) begin
      push_word({pick_sample(style), pick_sample(style)},
                (i == 0) ? field : len_t'($urandom));
    end
    events_total++;
    return len;
  endfunction

  // Stimulus: directed corner events, then random events with two long ones
  initial begin
    int   field;
    len_t len_field;
    in_bus.valid       = 1'b0;
    in_bus.sample_word = '0;
    in_bus.data_words  = '0;
    out_bus.ready      = 1'b0;
    rst_n              = 1'b0;

    // Length field of zero becomes two words; all-zero then all-ones samples
    push_word(32'h0000_0000, 14'd0);
    push_word(32'hFFFF_FFFF, 14'd0);
    // Length field of one; minimum in the high half, then a tie
    push_word(32'h0001_0002, 14'd1);
    push_word(32'h0003_0003, 14'd1);
    // Odd length; later length fields at the extremes are ignored
    push_word(32'h0009_0005, 14'd3);
    push_word(32'h0004_0007, 14'h3FFF);
    push_word(32'h0002_0004, 14'd0);
    // Five words: two for channel 0, three for channel 1, repeated minimum
    push_word(32'h8000_8000, 14'd5);
    push_word(32'h7FFF_0001, 14'h2AAA);
    push_word(32'h5555_AAAA, 14'h1555);
    push_word(32'hAAAA_5555, 14'd1);
    push_word(32'h0001_FFFF, 14'd8192);
    // Plain two-word event at full scale
    push_word(32'hFFFF_FFFF, 14'd2);
    push_word(32'hFFFF_FFFF, 14'd8191);
    events_total = 5;

    while (words_total < ITEM_TARGET) begin
      if (events_total == 20)
        void'(add_event(len_t'(LONG_WORDS), STYLE_ONES));
      if (events_total == 60)
        void'(add_event(len_t'(LONG_WORDS + 1), STYLE_ANY));
      field = $urandom_range(0, 9);
      if (field == 0)
        len_field = len_t'($urandom_range(0, 1));
      else if (field < 8)
        len_field = len_t'($urandom_range(2, 12));
      else
        len_field = len_t'($urandom_range(13, 40));
      void'(add_event(len_field, $urandom_range(STYLE_ANY, STYLE_ONES)));
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (words_sent != words_total || expected_summaries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d waveform words in %0d events and checked %0d channel summaries.",
             words_sent, events_total, summaries_checked);
    $display("Included clamped short lengths, ties, two long events and a %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Word driver: bursts of random length with random gaps between them
  always @(posedge clk) begin
    waveform_word_t item;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (in_bus.valid) begin
        track_word(in_bus.sample_word, in_bus.data_words);
        words_sent++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_bus.valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        item = pending_words.pop_front();
        in_bus.sample_word <= item.word;
        in_bus.data_words  <= item.words;
        in_bus.valid       <= 1'b1;
        if (burst_left == 0) burst_left = $urandom_range(1, 40);
        burst_left--;
        if (burst_left == 0)
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Summary receiver: one long hold-off, otherwise a rotating stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else if (!hold_done && words_sent >= 300) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_bus.ready <= 1'b0;
    end else begin
      pace_cnt <= pace_cnt + 1'b1;
      case (pace_cnt[8:7])
        RX_OPEN:   out_bus.ready <= 1'b1;
        RX_COIN:   out_bus.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_bus.ready <= ($urandom_range(0, 3) == 0);
        RX_MASK:   out_bus.ready <= STALL_MASK[pace_cnt[2:0]];
        default:   out_bus.ready <= 1'b1;
      endcase
    end
  end

  // Summary monitor: compare each transaction with the oldest expectation
  always @(posedge clk) begin
    summary_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_summaries.size() == 0) begin
        report_mismatch("unexpected summary, channel", out_bus.channel, -1);
      end else begin
        want = expected_summaries.pop_front();
        if (out_bus.channel !== want.channel)
          report_mismatch("channel", out_bus.channel, want.channel);
        if (out_bus.integral !== want.integral)
          report_mismatch("integral", out_bus.integral, want.integral);
        if (out_bus.minimum_value !== want.minimum_value)
          report_mismatch("minimum_value", out_bus.minimum_value, want.minimum_value);
        if (out_bus.minimum_index !== want.minimum_index)
          report_mismatch("minimum_index", out_bus.minimum_index, want.minimum_index);
        summaries_checked++;
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("timeout: %0d quiet cycles, %0d of %0d words sent, %0d summaries due",
                   quiet_cycles, words_sent, words_total, expected_summaries.size());
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

endmodule
